/* design/hrf_pkg.sv */
// Shared types, codes and constants of the hyperbolic Radon forward block.
package hrf_pkg;

  localparam int DEF_MAX_TIMES   = 256;
  localparam int DEF_MAX_PARAMS  = 64;
  localparam int DEF_MAX_OFFSETS = 64;

  localparam int STORE_DEPTH = 16384;
  localparam int STORE_AW    = 14;

  localparam int NUM_W  = 64;
  localparam int DEN_W  = 32;
  localparam int ROOT_W = 32;

  localparam logic [32:0] MAG_THRESHOLD = 33'd655;
  localparam logic [63:0] RATIO_CAP     = 64'h0000_0000_7FFF_FFFF;

  localparam logic [2:0] OP_LOAD_MODEL  = 3'd0;
  localparam logic [2:0] OP_LOAD_TIME   = 3'd1;
  localparam logic [2:0] OP_LOAD_OFFSET = 3'd2;
  localparam logic [2:0] OP_LOAD_PARAM  = 3'd3;
  localparam logic [2:0] OP_RUN         = 3'd4;
  localparam logic [2:0] OP_READ        = 3'd5;

  localparam logic [2:0] CFG_TIME_STEP      = 3'd0;
  localparam logic [2:0] CFG_SIN_SQ_THETA   = 3'd1;
  localparam logic [2:0] CFG_NEAREST_MODE   = 3'd2;
  localparam logic [2:0] CFG_TIMES_IN_USE   = 3'd3;
  localparam logic [2:0] CFG_PARAMS_IN_USE  = 3'd4;
  localparam logic [2:0] CFG_OFFSETS_IN_USE = 3'd5;
  localparam logic [2:0] CFG_DATA_LIMIT     = 3'd6;
  localparam logic [2:0] CFG_MODEL_LIMIT    = 3'd7;

  localparam logic [31:0] RST_TIME_STEP      = 32'd262;
  localparam logic [8:0]  RST_TIMES_IN_USE   = 9'd256;
  localparam logic [6:0]  RST_PARAMS_IN_USE  = 7'd64;
  localparam logic [6:0]  RST_OFFSETS_IN_USE = 7'd64;
  localparam logic [14:0] RST_LIMIT          = 15'd16384;

  typedef struct packed {
    logic [2:0]         op;
    logic [13:0]        index;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               run_done;
  } result_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RDATA, S_HQ_RD, S_HQ_WAIT, S_DIV_R, S_DIV_B, S_BSQ1, S_BSQ2,
    S_NEXT_Q, S_T_CHECK, S_T_WAIT, S_DIV_A, S_ASQ, S_SUM, S_SQRT, S_PLACE, S_ADD0,
    S_ADD1, S_DONE
  } state_t;

endpackage

/* design/hyperbolic_radon_forward.sv */
// Hyperbolic Radon forward operator: spreads a model panel into a data store.
// A load or an unused op leaves the block idle, and a read gives its result beat from the
// result register after the S_RDATA state. A run first clears the whole data store, one
// word a cycle, then for each offset and parameter pair makes two passes of the bit-serial
// divider (none for a zero parameter), steps past each skipped sample, and for each sample
// that is placed makes one divider pass, a square root and the read-modify-write of one or
// two data words; the done beat follows. After reset the same clearing pass runs before
// the first item is taken, while configuration writes are taken as ever.
module hyperbolic_radon_forward
  import hrf_pkg::*;
#(
  parameter int MAX_TIMES   = DEF_MAX_TIMES,
  parameter int MAX_PARAMS  = DEF_MAX_PARAMS,
  parameter int MAX_OFFSETS = DEF_MAX_OFFSETS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_wen,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NT_W = $clog2(MAX_TIMES + 1);
  localparam int NQ_W = $clog2(MAX_PARAMS + 1);
  localparam int NH_W = $clog2(MAX_OFFSETS + 1);
  localparam int TA_W = (MAX_TIMES > 1) ? $clog2(MAX_TIMES) : 1;
  localparam int QA_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int HA_W = (MAX_OFFSETS > 1) ? $clog2(MAX_OFFSETS) : 1;
  localparam int KW   = $clog2(MAX_PARAMS * MAX_TIMES + 1);
  localparam int JW   = $clog2(MAX_OFFSETS * MAX_TIMES + 65538);

  // Configuration registers.
  logic [31:0] time_step;
  logic [16:0] sin_sq_theta;
  logic        nearest_mode;
  logic [8:0]  times_in_use;
  logic [6:0]  params_in_use;
  logic [6:0]  offsets_in_use;
  logic [14:0] data_limit;
  logic [14:0] model_limit;

  logic [NT_W-1:0] nt;
  logic [NQ_W-1:0] nq;
  logic [NH_W-1:0] nh;
  logic [14:0]     ny;
  logic [14:0]     nx;
  logic [16:0]     one_minus_s;

  state_t state, state_next;
  logic   run_flag;
  logic [STORE_AW:0] clr_cnt;

  logic [NT_W-1:0] itau;
  logic [NQ_W-1:0] iq;
  logic [NH_W-1:0] ih;
  logic [KW-1:0]   base_k;
  logic [JW-1:0]   base_j;
  logic [KW-1:0]   k;
  logic [JW-1:0]   j;
  logic [JW-1:0]   j_reg;

  logic [30:0]        b;
  logic [61:0]        bb;
  logic [62:0]        bsq;
  logic [30:0]        a;
  logic [61:0]        aa;
  logic signed [31:0] m;
  logic [31:0]        it_reg;
  logic signed [31:0] w0;
  logic signed [31:0] w1;

  logic accept;
  logic itau_inc, itau_clr, q_step, result_go;

  // Memory ports.
  logic                model_we;
  logic [31:0]         model_rdata;
  logic                time_we;
  logic [31:0]         time_rdata;
  logic                offset_we;
  logic [31:0]         offset_rdata;
  logic                param_we;
  logic [31:0]         param_rdata;
  logic                data_we;
  logic [STORE_AW-1:0] data_waddr;
  logic [31:0]         data_wdata;
  logic [STORE_AW-1:0] data_raddr;
  logic [31:0]         data_rdata;

  logic             div_start, div_busy, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den;
  logic             sqrt_start, sqrt_busy, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  logic               hit_edge;
  logic               place_ok;
  logic [16:0]        frac;
  logic [16:0]        wt0;
  logic signed [49:0] p0;
  logic signed [49:0] p1;

  function automatic logic [31:0] sat_add(input logic [31:0] x, input logic signed [31:0] y);
    logic signed [32:0] s;
    s = 33'($signed(x)) + 33'(y);
    if (s > 33'sh0_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (s < -33'sh0_8000_0000) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  function automatic logic [30:0] cap_ratio(input logic [63:0] q);
    return (q > RATIO_CAP) ? 31'h7FFF_FFFF : q[30:0];
  endfunction

  assign nt = (32'(times_in_use) > 32'(MAX_TIMES)) ? NT_W'(MAX_TIMES) : NT_W'(times_in_use);
  assign nq = (32'(params_in_use) > 32'(MAX_PARAMS)) ? NQ_W'(MAX_PARAMS) : NQ_W'(params_in_use);
  assign nh = (32'(offsets_in_use) > 32'(MAX_OFFSETS)) ?
              NH_W'(MAX_OFFSETS) : NH_W'(offsets_in_use);
  assign ny = (data_limit > 15'(STORE_DEPTH)) ? 15'(STORE_DEPTH) : data_limit;
  assign nx = (model_limit > 15'(STORE_DEPTH)) ? 15'(STORE_DEPTH) : model_limit;
  assign one_minus_s = 17'h1_0000 - ((sin_sq_theta > 17'h1_0000) ? 17'h1_0000 : sin_sq_theta);

  assign item_stall = (state != S_IDLE) || (result_valid && result_stall);
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step      <= RST_TIME_STEP;
      sin_sq_theta   <= '0;
      nearest_mode   <= 1'b0;
      times_in_use   <= RST_TIMES_IN_USE;
      params_in_use  <= RST_PARAMS_IN_USE;
      offsets_in_use <= RST_OFFSETS_IN_USE;
      data_limit     <= RST_LIMIT;
      model_limit    <= RST_LIMIT;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_TIME_STEP:      time_step      <= cfg_data;
        CFG_SIN_SQ_THETA:   sin_sq_theta   <= cfg_data[16:0];
        CFG_NEAREST_MODE:   nearest_mode   <= cfg_data[0];
        CFG_TIMES_IN_USE:   times_in_use   <= cfg_data[8:0];
        CFG_PARAMS_IN_USE:  params_in_use  <= cfg_data[6:0];
        CFG_OFFSETS_IN_USE: offsets_in_use <= cfg_data[6:0];
        CFG_DATA_LIMIT:     data_limit     <= cfg_data[14:0];
        CFG_MODEL_LIMIT:    model_limit    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Placement arithmetic.
  assign k        = base_k + KW'(itau);
  assign j        = base_j + JW'(it_reg[31:16]);
  assign hit_edge = 48'(it_reg) == (48'(nt) << 16);
  assign place_ok = !hit_edge && (nearest_mode ? (48'(j) < 48'(ny))
                                               : ((48'(j) + 48'd1) < 48'(ny)));
  assign frac     = {1'b0, it_reg[15:0]};
  assign wt0      = 17'h1_0000 - frac;
  assign p0       = m * $signed({1'b0, wt0});
  assign p1       = m * $signed({1'b0, frac});

  assign model_we  = accept && (item.op == OP_LOAD_MODEL);
  assign time_we   = accept && (item.op == OP_LOAD_TIME) && (32'(item.index) < 32'(MAX_TIMES));
  assign offset_we = accept && (item.op == OP_LOAD_OFFSET) &&
                     (32'(item.index) < 32'(MAX_OFFSETS));
  assign param_we  = accept && (item.op == OP_LOAD_PARAM) &&
                     (32'(item.index) < 32'(MAX_PARAMS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    itau_inc   = 1'b0;
    itau_clr   = 1'b0;
    q_step     = 1'b0;
    result_go  = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = time_step;
    sqrt_start = 1'b0;
    data_we    = 1'b0;
    data_waddr = j_reg[STORE_AW-1:0];
    data_wdata = '0;
    data_raddr = item.index;
    unique case (state)
      S_CLEAR: begin
        data_we    = 1'b1;
        data_waddr = clr_cnt[STORE_AW-1:0];
        if (clr_cnt == (STORE_AW+1)'(STORE_DEPTH - 1)) begin
          if (!run_flag) begin
            state_next = S_IDLE;
          end else if (time_step == '0 || nh == '0 || nq == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_HQ_RD;
          end
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (item.op == OP_RUN) begin
            state_next = S_CLEAR;
          end else if (item.op == OP_READ) begin
            state_next = S_RDATA;
          end
        end
      end
      S_RDATA: state_next = S_IDLE;
      S_HQ_RD: state_next = S_HQ_WAIT;
      S_HQ_WAIT: begin
        if (param_rdata == '0) begin
          state_next = S_NEXT_Q;
        end else begin
          div_start  = 1'b1;
          div_num    = {offset_rdata, 32'h0} >> 16;
          div_den    = param_rdata;
          state_next = S_DIV_R;
        end
      end
      S_DIV_R: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_num    = {div_quo[47:0], 16'h0};
          state_next = S_DIV_B;
        end
      end
      S_DIV_B: if (div_done) state_next = S_BSQ1;
      S_BSQ1: state_next = S_BSQ2;
      S_BSQ2: begin
        itau_clr   = 1'b1;
        state_next = S_T_CHECK;
      end
      S_NEXT_Q: begin
        q_step = 1'b1;
        if ((32'(iq) + 1 == 32'(nq)) && (32'(ih) + 1 == 32'(nh))) begin
          state_next = S_DONE;
        end else begin
          state_next = S_HQ_RD;
        end
      end
      S_T_CHECK: begin
        if (itau == nt) begin
          state_next = S_NEXT_Q;
        end else if (32'(k) >= 32'(nx)) begin
          itau_inc = 1'b1;
        end else begin
          state_next = S_T_WAIT;
        end
      end
      S_T_WAIT: begin
        if (($signed(model_rdata) < 0 ? (33'd0 - 33'($signed(model_rdata)))
                                      : 33'(model_rdata)) <= MAG_THRESHOLD) begin
          itau_inc   = 1'b1;
          state_next = S_T_CHECK;
        end else begin
          div_start  = 1'b1;
          div_num    = {time_rdata, 32'h0} >> 16;
          state_next = S_DIV_A;
        end
      end
      S_DIV_A: if (div_done) state_next = S_ASQ;
      S_ASQ: state_next = S_SUM;
      S_SUM: begin
        sqrt_start = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: if (sqrt_done) state_next = S_PLACE;
      S_PLACE: begin
        data_raddr = j[STORE_AW-1:0];
        if (place_ok) begin
          state_next = S_ADD0;
        end else begin
          itau_inc   = 1'b1;
          state_next = S_T_CHECK;
        end
      end
      S_ADD0: begin
        data_we    = 1'b1;
        data_wdata = sat_add(data_rdata, w0);
        data_raddr = STORE_AW'(j_reg + 1'b1);
        if (nearest_mode) begin
          itau_inc   = 1'b1;
          state_next = S_T_CHECK;
        end else begin
          state_next = S_ADD1;
        end
      end
      S_ADD1: begin
        data_we    = 1'b1;
        data_waddr = STORE_AW'(j_reg + 1'b1);
        data_wdata = sat_add(data_rdata, w1);
        itau_inc   = 1'b1;
        state_next = S_T_CHECK;
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          result_go  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Run control: clearing counter and loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag <= 1'b0;
      clr_cnt  <= '0;
      itau     <= '0;
      iq       <= '0;
      ih       <= '0;
      base_k   <= '0;
      base_j   <= '0;
    end else begin
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (state_next != S_CLEAR) begin
          run_flag <= 1'b0;
          iq       <= '0;
          ih       <= '0;
          base_k   <= '0;
          base_j   <= '0;
        end
      end else if (accept && item.op == OP_RUN) begin
        run_flag <= 1'b1;
        clr_cnt  <= '0;
      end
      if (itau_clr) begin
        itau <= '0;
      end else if (itau_inc) begin
        itau <= itau + 1'b1;
      end
      if (q_step) begin
        if (32'(iq) + 1 == 32'(nq)) begin
          iq     <= '0;
          base_k <= '0;
          ih     <= ih + 1'b1;
          base_j <= base_j + JW'(nt);
        end else begin
          iq     <= iq + 1'b1;
          base_k <= base_k + KW'(nt);
        end
      end
    end
  end

  // Placement datapath registers.
  always_ff @(posedge clk) begin
    if (state == S_DIV_B && div_done) begin
      b <= cap_ratio(div_quo);
    end
    if (state == S_BSQ1) begin
      bb <= 62'(b) * 62'(b);
    end
    if (state == S_BSQ2) begin
      bsq <= 63'(bb[61:16]) * 63'(one_minus_s);
    end
    if (state == S_T_WAIT) begin
      m <= $signed(model_rdata);
    end
    if (state == S_DIV_A && div_done) begin
      a <= cap_ratio(div_quo);
    end
    if (state == S_ASQ) begin
      aa <= 62'(a) * 62'(a);
    end
    if (sqrt_done) begin
      it_reg <= sqrt_root;
    end
    if (state == S_PLACE) begin
      j_reg <= j;
      w0    <= nearest_mode ? m : p0[47:16];
      w1    <= p1[47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_RDATA || result_go) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RDATA) begin
      result.read_value <= $signed(data_rdata);
      result.run_done   <= 1'b0;
    end else if (result_go) begin
      result.read_value <= '0;
      result.run_done   <= 1'b1;
    end
  end

  hrf_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_model (
    .clk(clk), .we(model_we), .waddr(item.index), .wdata(item.value),
    .raddr(STORE_AW'(k)), .rdata(model_rdata)
  );

  hrf_ram #(.WIDTH(32), .DEPTH(MAX_TIMES)) u_time (
    .clk(clk), .we(time_we), .waddr(item.index[TA_W-1:0]), .wdata(item.value),
    .raddr(itau[TA_W-1:0]), .rdata(time_rdata)
  );

  hrf_ram #(.WIDTH(32), .DEPTH(MAX_OFFSETS)) u_offset (
    .clk(clk), .we(offset_we), .waddr(item.index[HA_W-1:0]), .wdata(item.value),
    .raddr(ih[HA_W-1:0]), .rdata(offset_rdata)
  );

  hrf_ram #(.WIDTH(32), .DEPTH(MAX_PARAMS)) u_param (
    .clk(clk), .we(param_we), .waddr(item.index[QA_W-1:0]), .wdata(item.value),
    .raddr(iq[QA_W-1:0]), .rdata(param_rdata)
  );

  // Scatter-adds are strictly one word at a time, so a read never overtakes a pending write.
  hrf_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_data (
    .clk(clk), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
    .raddr(data_raddr), .rdata(data_rdata)
  );

  hrf_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .done(div_done), .quo(div_quo)
  );

  hrf_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(64'(aa) + 64'(bsq)),
    .busy(sqrt_busy), .done(sqrt_done), .root(sqrt_root)
  );

  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider started while busy");

  assert property (@(posedge clk) disable iff (rst) sqrt_start |-> !sqrt_busy)
    else $error("square root started while busy");

  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == S_RDATA || $past(state) == S_DONE))
    else $error("result beat raised outside a read or run completion");

  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE) |-> !data_we)
    else $error("data store written while idle");

endmodule

/* design/hrf_ram.sv */
// Generic single-write, single-read memory with registered read data.
module hrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/hrf_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module hrf_div
  import hrf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W);

  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  assign rem_sh = {rem[DEN_W-1:0], quo[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      den_q <= den;
      rem   <= '0;
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

/* design/hrf_sqrt.sv */
// Digit-by-digit integer square root, two radicand bits per cycle.
module hrf_sqrt
  import hrf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  radicand,
  output logic              busy,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int CW = $clog2(ROOT_W);
  localparam int RW = ROOT_W + 3;

  logic [NUM_W-1:0] x;
  logic [RW-1:0]    rem;
  logic [CW-1:0]    cnt;
  logic [RW-1:0]    rem_sh;
  logic [RW-1:0]    trial;
  logic             fits;

  assign rem_sh = {rem[RW-3:0], x[NUM_W-1:NUM_W-2]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      x    <= {x[NUM_W-3:0], 2'b00};
      rem  <= fits ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

/* sim/tb.sv */
// Self-checking testbench for the hyperbolic Radon forward block.
`timescale 1ns / 1ps

module tb;
  import hrf_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int PRESSURE_HOLD  = 400;

  // Op codes that the block ignores.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  item_t       item = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        cfg_wen = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  hyperbolic_radon_forward i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Our own copy of the block's registers and stores.
  logic [31:0] dt_reg = 32'd262;
  logic [16:0] sinsq_reg = '0;
  logic        nearest_reg = 1'b0;
  logic [8:0]  nt_reg = 9'd256;
  logic [6:0]  nq_reg = 7'd64;
  logic [6:0]  nh_reg = 7'd64;
  logic [14:0] ny_reg = 15'd16384;
  logic [14:0] nx_reg = 15'd16384;

  int          model_mem [STORE_DEPTH];
  logic [31:0] time_mem [DEF_MAX_TIMES];
  logic [31:0] offs_mem [DEF_MAX_OFFSETS];
  logic [31:0] par_mem [DEF_MAX_PARAMS];
  int          data_mem [STORE_DEPTH];

  item_t   pending_items[$];
  result_t expected_beats[$];
  int      errors = 0;
  int      n_pushed = 0, n_accepted = 0, n_runs = 0, n_reads = 0, n_phases = 0;
  logic    quiet = 1'b0;
  logic    press_req = 1'b0;
  logic    press_done = 1'b0;
  int      gap = 0;
  int      hold_cnt = 0;
  int      idle_cycles = 0;

  function automatic int unsigned clamp(int unsigned v, int unsigned hi);
    return v > hi ? hi : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint weigh(int m, longint w);
    longint p;
    p = longint'(m) * w;
    if (p >= 0) return p / 65536;
    return -((-p + 65535) / 65536);
  endfunction

  task automatic sat_add(longint unsigned j, longint v);
    longint s;
    s = longint'(data_mem[j]) + v;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    data_mem[j] = int'(s);
  endtask

  task automatic spread_model_into_data();
    longint unsigned nt, nq, nh, ny, nx, oms, dtl, h, q, r, b, bsq, k, a, itv, fl, fr, j;
    longint mag;
    int m;
    nt = clamp(nt_reg, DEF_MAX_TIMES);
    nq = clamp(nq_reg, DEF_MAX_PARAMS);
    nh = clamp(nh_reg, DEF_MAX_OFFSETS);
    ny = clamp(ny_reg, STORE_DEPTH);
    nx = clamp(nx_reg, STORE_DEPTH);
    oms = 65536 - clamp(sinsq_reg, 65536);
    dtl = dt_reg;
    foreach (data_mem[i]) data_mem[i] = 0;
    if (dtl == 0) return;
    for (longint unsigned ih = 0; ih < nh; ih++) begin
      h = offs_mem[ih];
      for (longint unsigned iq = 0; iq < nq; iq++) begin
        q = par_mem[iq];
        if (q == 0) continue;
        r = (h << 16) / q;
        b = (r << 16) / dtl;
        if (b > RATIO_CAP) b = RATIO_CAP;
        bsq = ((b * b) >> 16) * oms;
        for (longint unsigned itau = 0; itau < nt; itau++) begin
          k = iq * nt + itau;
          if (k >= nx) continue;
          m = model_mem[k];
          mag = m < 0 ? -longint'(m) : longint'(m);
          if (mag <= 655) continue;
          a = (longint'(time_mem[itau]) << 16) / dtl;
          if (a > RATIO_CAP) a = RATIO_CAP;
          itv = int_sqrt(a * a + bsq);
          if (itv == (nt << 16)) continue;
          fl = itv >> 16;
          fr = itv & 64'hFFFF;
          j = ih * nt + fl;
          if (nearest_reg) begin
            if (j < ny) sat_add(j, m);
          end else if (j + 1 < ny) begin
            sat_add(j, weigh(m, 65536 - fr));
            sat_add(j + 1, weigh(m, fr));
          end
        end
      end
    end
  endtask

  task automatic predict_item(item_t it);
    result_t e;
    case (it.op)
      OP_LOAD_MODEL: model_mem[it.index] = it.value;
      OP_LOAD_TIME: if (it.index < DEF_MAX_TIMES) time_mem[it.index] = it.value;
      OP_LOAD_OFFSET: if (it.index < DEF_MAX_OFFSETS) offs_mem[it.index] = it.value;
      OP_LOAD_PARAM: if (it.index < DEF_MAX_PARAMS) par_mem[it.index] = it.value;
      OP_RUN: begin
        spread_model_into_data();
        e.read_value = '0;
        e.run_done = 1'b1;
        expected_beats.push_back(e);
        n_runs++;
      end
      OP_READ: begin
        e.read_value = data_mem[it.index];
        e.run_done = 1'b0;
        expected_beats.push_back(e);
        n_reads++;
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch in %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 4);
  endfunction

  // Input driver: a stalled beat is held, otherwise after any random gap the next pending item goes out.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      gap <= 0;
    end else begin
      if (item_valid && !item_stall) begin
        predict_item(item);
        n_accepted++;
        if (n_accepted % 80 == 0) quiet <= ($urandom_range(0, 3) == 0);
      end
      if (item_valid && item_stall) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
        item_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        item <= pending_items.pop_front();
        item_valid <= 1'b1;
        gap <= pick_gap();
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random holds, plus one long hold once result beats start coming in a pressure phase.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_cnt <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      result_stall <= 1'b1;
    end else if (press_req && !press_done && result_valid) begin
      hold_cnt <= PRESSURE_HOLD;
      press_done <= 1'b1;
      result_stall <= 1'b1;
    end else if (quiet) begin
      result_stall <= 1'b0;
    end else if ($urandom_range(0, 99) == 0) begin
      hold_cnt <= $urandom_range(10, 40);
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // Monitor: each result beat against the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (!rst && result_valid && !result_stall) begin
      if (expected_beats.size() == 0) begin
        report("unexpected beat", result.read_value, 32'h0);
      end else begin
        e = expected_beats.pop_front();
        if (result.read_value !== e.read_value)
          report("read_value", result.read_value, e.read_value);
        if (result.run_done !== e.run_done)
          report("run_done", 32'(result.run_done), 32'(e.run_done));
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles with no beat", WATCHDOG_LIMIT);
      $display("hyperbolic_radon_forward regression: fail");
      $finish;
    end
  end

  task automatic set_reg(logic [2:0] idx, logic [31:0] d);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    case (idx)
      CFG_TIME_STEP:      dt_reg = d;
      CFG_SIN_SQ_THETA:   sinsq_reg = d[16:0];
      CFG_NEAREST_MODE:   nearest_reg = d[0];
      CFG_TIMES_IN_USE:   nt_reg = d[8:0];
      CFG_PARAMS_IN_USE:  nq_reg = d[6:0];
      CFG_OFFSETS_IN_USE: nh_reg = d[6:0];
      CFG_DATA_LIMIT:     ny_reg = d[14:0];
      CFG_MODEL_LIMIT:    nx_reg = d[14:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || item_valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic push(logic [2:0] op, int unsigned idx, logic [31:0] val);
    item_t it;
    it.op = op;
    it.index = idx[13:0];
    it.value = val;
    pending_items.push_back(it);
    n_pushed++;
  endtask

  function automatic logic [31:0] axis_val(longint unsigned lim);
    int unsigned c;
    c = $urandom_range(0, 19);
    if (c < 16) return 32'(longint'($urandom) % lim);
    if (c == 16) return 32'h0;
    if (c == 17) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] param_val();
    int unsigned c;
    c = $urandom_range(0, 19);
    if (c < 16) return $urandom_range(32'h8000, 32'h30000);
    if (c == 16) return 32'h0;
    return $urandom;
  endfunction

  function automatic logic [31:0] model_val();
    int unsigned c;
    int v;
    c = $urandom_range(0, 99);
    if (c < 70) v = $urandom_range(656, 32'h200000);
    else if (c < 85) v = $urandom_range(0, 656);
    else if (c < 90) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    else return $urandom;
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // One phase: idle, write every register, load what the run touches plus stray items, run, read back.
  task automatic do_phase(logic [31:0] dt, logic [16:0] s, logic nm, logic [8:0] nt,
                          logic [6:0] nq, logic [6:0] nh, logic [14:0] ny, logic [14:0] nx,
                          logic pressure);
    int unsigned ent, enq, enh, enx, nk, nr;
    longint unsigned lim;
    wait_idle();
    set_reg(CFG_TIME_STEP, dt);
    set_reg(CFG_SIN_SQ_THETA, 32'(s));
    set_reg(CFG_NEAREST_MODE, 32'(nm));
    set_reg(CFG_TIMES_IN_USE, 32'(nt));
    set_reg(CFG_PARAMS_IN_USE, 32'(nq));
    set_reg(CFG_OFFSETS_IN_USE, 32'(nh));
    set_reg(CFG_DATA_LIMIT, 32'(ny));
    set_reg(CFG_MODEL_LIMIT, 32'(nx));
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
    n_phases++;
    ent = clamp(32'(nt), DEF_MAX_TIMES);
    enq = clamp(32'(nq), DEF_MAX_PARAMS);
    enh = clamp(32'(nh), DEF_MAX_OFFSETS);
    enx = clamp(32'(nx), STORE_DEPTH);
    lim = longint'(ent) * dt;
    if (lim == 0) lim = 1;
    if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
    for (int unsigned i = 0; i < ent; i++) push(OP_LOAD_TIME, i, axis_val(lim));
    for (int unsigned i = 0; i < enh; i++) push(OP_LOAD_OFFSET, i, axis_val(lim));
    for (int unsigned i = 0; i < enq; i++) push(OP_LOAD_PARAM, i, param_val());
    nk = clamp(enq * ent, enx);
    for (int unsigned i = 0; i < nk; i++) push(OP_LOAD_MODEL, i, model_val());
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 4))
        0: push(OP_SPARE_6, $urandom_range(0, 16383), $urandom);
        1: push(OP_SPARE_7, $urandom_range(0, 16383), $urandom);
        2: push(OP_LOAD_TIME, $urandom_range(DEF_MAX_TIMES, 16383), $urandom);
        3: push(OP_LOAD_OFFSET, $urandom_range(DEF_MAX_OFFSETS, 16383), $urandom);
        default: push(OP_LOAD_PARAM, $urandom_range(DEF_MAX_PARAMS, 16383), $urandom);
      endcase
    end
    push(OP_RUN, $urandom_range(0, 16383), $urandom);
    if (pressure) press_req = 1'b1;
    nr = clamp(enh * ent + 2, 40);
    for (int unsigned i = 0; i < nr; i++) push(OP_READ, i, $urandom);
    repeat (3) push(OP_READ, $urandom_range(0, 16383), $urandom);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // Data store is clear after reset, before any run.
    @(negedge clk);
    push(OP_READ, 0, 32'h0);
    push(OP_READ, 16383, 32'hFFFF_FFFF);
    // Directed settings: plain case, zero step, tiny step, huge step with no data room,
    // longest trace, every parameter with no model room, every offset, and no times.
    do_phase(32'h10000, 17'd0, 1'b0, 9'd4, 7'd2, 7'd2, 15'd16384, 15'd16384, 1'b1);
    do_phase(32'h0, 17'd0, 1'b0, 9'd4, 7'd2, 7'd2, 15'd16384, 15'd16384, 1'b0);
    do_phase(32'h1, 17'd65536, 1'b1, 9'd4, 7'd2, 7'd2, 15'h7FFF, 15'h7FFF, 1'b0);
    do_phase(32'hFFFF_FFFF, 17'h1FFFF, 1'b0, 9'd8, 7'd2, 7'd2, 15'd0, 15'd16384, 1'b0);
    do_phase(32'd262, 17'd0, 1'b1, 9'h1FF, 7'd1, 7'd1, 15'd16384, 15'd40, 1'b0);
    do_phase(32'h10000, 17'd30000, 1'b0, 9'd1, 7'h7F, 7'd1, 15'd16384, 15'd0, 1'b0);
    do_phase(32'h10000, 17'd0, 1'b1, 9'd1, 7'd1, 7'h7F, 15'd16384, 15'd16384, 1'b0);
    do_phase(32'h10000, 17'd0, 1'b0, 9'd0, 7'd4, 7'd4, 15'd16384, 15'd16384, 1'b0);
    while (n_pushed < 700) begin
      logic [8:0]  nt;
      logic [6:0]  nq, nh;
      logic [14:0] ny, nx;
      nt = 9'($urandom_range(1, 16));
      nq = 7'($urandom_range(1, 4));
      nh = 7'($urandom_range(1, 4));
      case ($urandom_range(0, 2))
        0: ny = 15'd16384;
        1: ny = 15'($urandom_range(0, nh * nt + 2));
        default: ny = 15'h7FFF;
      endcase
      nx = $urandom_range(0, 2) != 0 ? 15'd16384 : 15'($urandom_range(0, nq * nt));
      do_phase($urandom_range(32'h40, 32'h40000),
               $urandom_range(0, 9) == 0 ? 17'h1FFFF : 17'($urandom_range(0, 65536)),
               1'($urandom_range(0, 1)), nt, nq, nh, ny, nx, !press_req);
    end
    wait_idle();
    repeat (300) @(posedge clk);
    if (expected_beats.size() != 0) report("leftover expectations", expected_beats.size(), 0);
    $display("covered %0d phases of settings, %0d items taken, %0d runs and %0d reads checked",
             n_phases, n_accepted, n_runs, n_reads);
    if (errors == 0) begin
      $display("hyperbolic_radon_forward regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("hyperbolic_radon_forward regression: fail");
    end
    $finish;
  end

endmodule
